>>> rtl/core/iol_pkg.sv
`default_nettype none

package iol_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 6;
  localparam int CNT_W        = 5;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 16;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INDEX = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins_en;
    logic             rem_en;
    logic [CNT_W-1:0] idx;
  } shift_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/iol_cell.sv
`default_nettype none

module iol_cell
  import iol_pkg::*;
#(
  parameter int CELL_INDEX = 0
) (
  input  wire logic              clk,
  input  wire shift_ctrl_t       ctrl,
  input  wire logic [DATA_W-1:0] left_value,
  input  wire logic [DATA_W-1:0] right_value,
  input  wire logic [DATA_W-1:0] new_value,
  output logic      [DATA_W-1:0] value
);

  localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(CELL_INDEX);

  logic [DATA_W-1:0] value_next;

  // On insert the cell at the index takes the new value and cells above it
  // take their lower neighbor; on remove the index and above take the upper one.
  always_comb begin
    value_next = value;
    if (ctrl.ins_en) begin
      if (MY_INDEX == ctrl.idx) begin
        value_next = new_value;
      end else if (MY_INDEX > ctrl.idx) begin
        value_next = left_value;
      end
    end else if (ctrl.rem_en) begin
      if (MY_INDEX >= ctrl.idx) begin
        value_next = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

>>> rtl/core/indexed_ordered_list.sv
// Throughput: one item per cycle while out_ready takes each result; every cell
// of the chain shifts or holds in the same cycle, and the result register
// frees itself as the result is taken; each result is registered.
// Reset: rst clears the entry count and the result valid flag; the stored
// entries keep whatever they hold and are only read once written.
`default_nettype none

module indexed_ordered_list
  import iol_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [CMD_W-1:0]           command,
  input  wire logic signed [POS_W-1:0]    position,
  input  wire logic signed [DATA_W-1:0]   value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [STATUS_W-1:0]        status,
  output logic signed [DATA_W-1:0]        read_value,
  output logic      [CNT_W-1:0]           entry_count
);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  // Entry count of the list.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic [DATA_W-1:0] cell_value [CAPACITY];

  logic              accept;
  logic              pos_tail;
  logic              pos_nonneg;
  logic [CNT_W-1:0]  pos_u;
  shift_ctrl_t       ctrl;
  logic [STATUS_W-1:0] status_next;
  logic [CNT_W-1:0]  rd_idx;
  logic              rd_en;
  logic [DATA_W-1:0] rd_data;

  // The result register accepts a new item whenever it is empty or its
  // result is being taken in this cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Position decode: all ones is the tail marker; a clear sign bit is a
  // plain index of up to 31.
  assign pos_tail   = (position == {POS_W{1'b1}});
  assign pos_nonneg = !position[POS_W-1];
  assign pos_u      = position[CNT_W-1:0];

  always_comb begin
    ctrl        = '0;
    status_next = ST_INDEX;
    count_next  = count;
    rd_en       = 1'b0;
    rd_idx      = pos_u;
    case (command)
      CMD_INSERT: begin
        if (pos_tail || (pos_nonneg && pos_u <= count)) begin
          if (count >= CAP) begin
            status_next = ST_FULL;
          end else begin
            status_next = ST_OK;
            ctrl.ins_en = accept;
            ctrl.idx    = pos_tail ? count : pos_u;
            count_next  = count + CNT_W'(1);
          end
        end
      end
      CMD_REMOVE: begin
        if (pos_nonneg && pos_u < count) begin
          status_next = ST_OK;
          ctrl.rem_en = accept;
          ctrl.idx    = pos_u;
          count_next  = count - CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (pos_tail && count != '0) begin
          status_next = ST_OK;
          rd_en       = 1'b1;
          rd_idx      = count - CNT_W'(1);
        end else if (pos_nonneg && pos_u < count) begin
          status_next = ST_OK;
          rd_en       = 1'b1;
        end
      end
      default: begin
        status_next = ST_INDEX;
      end
    endcase
  end

  // Read select over the cells; only a position below the count is read.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rd_en && rd_idx == CNT_W'(i)) begin
        rd_data = cell_value[i];
      end
    end
  end

  // The chain of cells: each one sees its lower and upper neighbor.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_value;
    logic [DATA_W-1:0] right_value;

    if (g == 0) begin : g_first
      assign left_value = value;
    end else begin : g_mid
      assign left_value = cell_value[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_value = cell_value[g];
    end else begin : g_inner
      assign right_value = cell_value[g+1];
    end

    iol_cell #(
      .CELL_INDEX(g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .left_value (left_value),
      .right_value(right_value),
      .new_value  (value),
      .value      (cell_value[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      read_value  <= rd_data;
      entry_count <= count_next;
    end
  end

endmodule

`default_nettype wire
